// ----- rtl/dmlfo_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual multiwave LFO package
// Shared types, codes and the sine table for the two-channel LFO.
// ----------------------------------------------------------------------------
package dmlfo_pkg;

	localparam int KNOB_W   = 10;
	localparam int TIMER_W  = 16;
	localparam int LEVEL_W  = 8;
	localparam int PHASE_W  = 8;
	localparam int DELAY_W  = 7;
	localparam int LFSR_W   = 16;
	localparam int TABLE_DEPTH = 256;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 7'd100;
	localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'h0001;
	localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 16'hB400;
	localparam logic [KNOB_W-1:0]  SHAPE_BAND_RESET = 10'd30;
	localparam logic [KNOB_W-1:0]  RATE_BAND_RESET  = 10'd10;

	localparam logic [0:0] REG_SHAPE_BAND = 1'b0;
	localparam logic [0:0] REG_RATE_BAND  = 1'b1;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SHAPE = 2'd1,
		CMD_RATE  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		WAVE_SINE  = 3'd0,
		WAVE_SAW   = 3'd1,
		WAVE_RSAW  = 3'd2,
		WAVE_TRI   = 3'd3,
		WAVE_SQ_A  = 3'd4,
		WAVE_HOLD  = 3'd5,
		WAVE_SQ_B  = 3'd6,
		WAVE_SQ_C  = 3'd7
	} wave_t;

	typedef struct packed {
		logic tick;
		logic shape;
		logic rate;
	} lane_req_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [DELAY_W-1:0] delay;
		logic               noise_take;
	} lane_resp_t;

	localparam logic [TABLE_DEPTH-1:0][LEVEL_W-1:0] SINE_ROM = {
		8'h7c,8'h79,8'h76,8'h73,8'h70,8'h6d,8'h6a,8'h67,8'h63,8'h60,8'h5d,8'h5a,8'h57,8'h54,8'h51,8'h4f,
		8'h4c,8'h49,8'h46,8'h43,8'h40,8'h3e,8'h3b,8'h38,8'h36,8'h33,8'h31,8'h2e,8'h2c,8'h2a,8'h27,8'h25,
		8'h23,8'h21,8'h1f,8'h1d,8'h1b,8'h19,8'h17,8'h15,8'h13,8'h12,8'h10,8'h0f,8'h0d,8'h0c,8'h0a,8'h09,
		8'h08,8'h07,8'h06,8'h05,8'h04,8'h03,8'h03,8'h02,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h02,8'h03,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,
		8'h0a,8'h0c,8'h0d,8'h0f,8'h10,8'h12,8'h13,8'h15,8'h17,8'h19,8'h1b,8'h1d,8'h1f,8'h21,8'h23,8'h25,
		8'h27,8'h2a,8'h2c,8'h2e,8'h31,8'h33,8'h36,8'h38,8'h3b,8'h3e,8'h40,8'h43,8'h46,8'h49,8'h4c,8'h4f,
		8'h51,8'h54,8'h57,8'h5a,8'h5d,8'h60,8'h63,8'h67,8'h6a,8'h6d,8'h70,8'h73,8'h76,8'h79,8'h7c,8'h80,
		8'h83,8'h86,8'h89,8'h8c,8'h8f,8'h92,8'h95,8'h98,8'h9c,8'h9f,8'ha2,8'ha5,8'ha8,8'hab,8'hae,8'hb0,
		8'hb3,8'hb6,8'hb9,8'hbc,8'hbf,8'hc1,8'hc4,8'hc7,8'hc9,8'hcc,8'hce,8'hd1,8'hd3,8'hd5,8'hd8,8'hda,
		8'hdc,8'hde,8'he0,8'he2,8'he4,8'he6,8'he8,8'hea,8'hec,8'hed,8'hef,8'hf0,8'hf2,8'hf3,8'hf5,8'hf6,
		8'hf7,8'hf8,8'hf9,8'hfa,8'hfb,8'hfc,8'hfc,8'hfd,8'hfe,8'hfe,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hfe,8'hfe,8'hfd,8'hfc,8'hfc,8'hfb,8'hfa,8'hf9,8'hf8,8'hf7,8'hf6,
		8'hf5,8'hf3,8'hf2,8'hf0,8'hef,8'hed,8'hec,8'hea,8'he8,8'he6,8'he4,8'he2,8'he0,8'hde,8'hdc,8'hda,
		8'hd8,8'hd5,8'hd3,8'hd1,8'hce,8'hcc,8'hc9,8'hc7,8'hc4,8'hc1,8'hbf,8'hbc,8'hb9,8'hb6,8'hb3,8'hb0,
		8'hae,8'hab,8'ha8,8'ha5,8'ha2,8'h9f,8'h9c,8'h98,8'h95,8'h92,8'h8f,8'h8c,8'h89,8'h86,8'h83,8'h80
	};

endpackage

// ----- rtl/dual_multiwave_lfo_unit.sv -----
// ----------------------------------------------------------------------------
// Dual multiwave LFO unit
// Per-channel LFO with eight waves, knob dead bands and next tick time.
// ----------------------------------------------------------------------------
// The unit accepts one word per clock cycle while the output is not blocked. The
// result of a tick is registered in the input register and then in the output
// register, where a stall can hold it; knob words produce no output. Each word is
// captured in an input register, the addressed channel lane updates its state
// in a single registered pass, and the tick result lands in an output register
// that can hold while the downstream side stalls. Channel indexes at or above
// CHANNELS and the unused command code are dropped without a result.
module dual_multiwave_lfo_unit
	import dmlfo_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // knob_reading [9:0], timer_now [25:10], zero fill
	input  logic [2:0]  s_tuser,   // cmd [1:0], channel [2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // level [7:0], next_compare [23:8]
	output logic        m_tuser,   // out_channel [0]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_addr,
	input  logic [9:0]  cfg_wdata
);

	logic [KNOB_W-1:0]  shape_band_q;
	logic [KNOB_W-1:0]  rate_band_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic [LFSR_W-1:0]  lfsr_next;

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               channel_s1;
	logic [KNOB_W-1:0]  reading_s1;
	logic [TIMER_W-1:0] now_s1;

	logic               out_valid_q;
	logic               out_channel_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIMER_W-1:0] next_q;

	logic               out_free;
	logic               fire_s1;
	logic               chan_ok;
	logic               tick_s1;
	lane_resp_t         resp [CHANNELS];
	lane_resp_t         sel;
	logic [TIMER_W:0]   sum;
	logic [TIMER_W-1:0] next_compare;

	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign chan_ok  = int'(channel_s1) < CHANNELS;
	assign tick_s1  = fire_s1 && chan_ok && (cmd_s1 == CMD_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_band_q <= SHAPE_BAND_RESET;
			rate_band_q  <= RATE_BAND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SHAPE_BAND: shape_band_q <= cfg_wdata;
				REG_RATE_BAND:  rate_band_q  <= cfg_wdata;
				default:        shape_band_q <= shape_band_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= cmd_t'(s_tuser[1:0]);
			channel_s1 <= s_tuser[2];
			reading_s1 <= s_tdata[9:0];
			now_s1     <= s_tdata[25:10];
		end
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		lane_req_t req;
		logic      hit;

		assign hit       = fire_s1 && (int'(channel_s1) == i);
		assign req.tick  = hit && (cmd_s1 == CMD_TICK);
		assign req.shape = hit && (cmd_s1 == CMD_SHAPE);
		assign req.rate  = hit && (cmd_s1 == CMD_RATE);

		dmlfo_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.req          (req),
			.knob_reading (reading_s1),
			.shape_band   (shape_band_q),
			.rate_band    (rate_band_q),
			.noise_byte   (lfsr_next[LEVEL_W-1:0]),
			.resp         (resp[i])
		);
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (int'(channel_s1) == i) sel = resp[i];
		end
	end

	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
		end else if (tick_s1 && sel.noise_take) begin
			lfsr_q <= lfsr_next;
		end
	end

	// A sum that passes the top of the timer wraps one count further.
	assign sum          = {1'b0, now_s1} + (TIMER_W+1)'(sel.delay);
	assign next_compare = sum[TIMER_W] ? sum[TIMER_W-1:0] + 16'd1 : sum[TIMER_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_s1) begin
			out_channel_q <= channel_s1;
			level_q       <= sel.level;
			next_q        <= next_compare;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {next_q, level_q};
	assign m_tuser  = out_channel_q;

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tick_s1))
		else $error("output word appeared without a tick");

	a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a blocked word");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("noise register reached the all-zero state");

	a_out_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (int'(out_channel_q) < CHANNELS))
		else $error("output word names a missing channel");

endmodule

// ----- rtl/dmlfo_lane.sv -----
// ----------------------------------------------------------------------------
// Dual multiwave LFO channel lane
// Holds one oscillator's state, steps its wave on a tick and applies knob
// readings through their dead bands.
// ----------------------------------------------------------------------------
module dmlfo_lane
	import dmlfo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_req_t          req,
	input  logic [KNOB_W-1:0]  knob_reading,
	input  logic [KNOB_W-1:0]  shape_band,
	input  logic [KNOB_W-1:0]  rate_band,
	input  logic [LEVEL_W-1:0] noise_byte,
	output lane_resp_t         resp
);

	logic [PHASE_W-1:0] phase_q;
	wave_t              wave_q;
	logic [DELAY_W-1:0] delay_q;
	logic               tri_falling_q;
	logic [KNOB_W-1:0]  last_shape_q;
	logic [KNOB_W-1:0]  last_rate_q;
	logic [LEVEL_W-1:0] held_q;
	logic [7:0]         hold_count_q;

	logic [PHASE_W-1:0] phase_d;
	logic               tri_falling_d;
	logic [LEVEL_W-1:0] held_d;
	logic [LEVEL_W-1:0] level;
	logic               noise_take;
	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] phase_dec;
	logic [PHASE_W-1:0] phase_up2;
	logic [PHASE_W-1:0] phase_dn2;
	logic [PHASE_W-1:0] phase_sq;
	logic               sq_low;
	logic               shape_take;
	logic               rate_take;
	logic [17:0]        div_prod;
	wave_t              shape_code;

	function automatic logic band_pass(input logic [KNOB_W-1:0] r, input logic [KNOB_W-1:0] last,
		input logic [KNOB_W-1:0] band);
		logic [KNOB_W:0] r_plus;
		logic [KNOB_W:0] last_plus;
		r_plus    = {1'b0, r} + {1'b0, band};
		last_plus = {1'b0, last} + {1'b0, band};
		return (r_plus <= {1'b0, last}) || ({1'b0, r} >= last_plus);
	endfunction

	assign phase_inc = phase_q + 8'd1;
	assign phase_dec = phase_q - 8'd1;
	assign phase_up2 = phase_q + 8'd2;
	assign phase_dn2 = phase_q - 8'd2;
	assign sq_low    = phase_inc < 8'd126;
	assign phase_sq  = (phase_inc >= 8'd252) ? phase_inc - 8'd252 : phase_inc;

	always_comb begin
		phase_d       = phase_q;
		tri_falling_d = tri_falling_q;
		held_d        = held_q;
		noise_take    = 1'b0;
		level         = '0;
		unique case (wave_q)
			WAVE_SINE: begin
				level   = SINE_ROM[phase_q];
				phase_d = phase_inc;
			end
			WAVE_SAW: begin
				phase_d = phase_inc;
				level   = phase_inc;
			end
			WAVE_RSAW: begin
				phase_d = phase_dec;
				level   = phase_dec;
			end
			WAVE_TRI: begin
				if (tri_falling_q) begin
					phase_d = phase_dn2;
					if (phase_dn2 == 8'd0) tri_falling_d = 1'b0;
				end else begin
					phase_d = phase_up2;
					if (phase_up2 == 8'd254) tri_falling_d = 1'b1;
				end
				level = phase_d;
			end
			WAVE_SQ_A: begin
				phase_d = phase_sq;
				level   = sq_low ? 8'h7F : 8'hFE;
			end
			WAVE_SQ_B: begin
				phase_d = phase_sq;
				level   = sq_low ? 8'h01 : 8'h7F;
			end
			WAVE_SQ_C: begin
				phase_d = phase_sq;
				level   = sq_low ? 8'h01 : 8'hFE;
			end
			WAVE_HOLD: begin
				if (hold_count_q == 8'd0) begin
					held_d     = noise_byte;
					noise_take = 1'b1;
				end
				level = held_d;
			end
			default: begin
				level = '0;
			end
		endcase
	end

	always_comb begin
		priority if (knob_reading < 10'd100) shape_code = WAVE_SINE;
		else if (knob_reading < 10'd200)     shape_code = WAVE_SAW;
		else if (knob_reading < 10'd300)     shape_code = WAVE_RSAW;
		else if (knob_reading < 10'd400)     shape_code = WAVE_TRI;
		else if (knob_reading < 10'd700)     shape_code = WAVE_SQ_A;
		else if (knob_reading < 10'd800)     shape_code = WAVE_SQ_B;
		else if (knob_reading < 10'd900)     shape_code = WAVE_SQ_C;
		else                                 shape_code = WAVE_HOLD;
	end

	// Reading over ten as a reciprocal multiply, exact for all 10-bit readings.
	assign div_prod   = 18'(knob_reading) * 18'd205;
	assign shape_take = band_pass(knob_reading, last_shape_q, shape_band);
	assign rate_take  = band_pass(knob_reading, last_rate_q, rate_band);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			wave_q        <= WAVE_SINE;
			delay_q       <= DELAY_RESET;
			tri_falling_q <= 1'b0;
			last_shape_q  <= '0;
			last_rate_q   <= '0;
			held_q        <= '0;
			hold_count_q  <= '0;
		end else begin
			if (req.tick) begin
				phase_q       <= phase_d;
				tri_falling_q <= tri_falling_d;
				held_q        <= held_d;
				if (wave_q == WAVE_HOLD) hold_count_q <= hold_count_q + 8'd1;
			end
			if (req.shape && shape_take) begin
				last_shape_q <= knob_reading;
				wave_q       <= shape_code;
			end
			if (req.rate && rate_take) begin
				last_rate_q <= knob_reading;
				delay_q     <= div_prod[17:11];
			end
		end
	end

	assign resp.level      = level;
	assign resp.delay      = delay_q;
	assign resp.noise_take = noise_take;

endmodule
